// File: design/acc_pkg.sv
// Shared types, codes, reset values and helpers of the alarm clock controller.
`default_nettype none

package acc_pkg;

    // Event codes on the op field
    localparam logic [1:0] OP_SECOND = 2'd0;
    localparam logic [1:0] OP_RING   = 2'd1;
    localparam logic [1:0] OP_KEY    = 2'd2;

    // Key codes
    localparam logic [2:0] KEY_MODE    = 3'd0;
    localparam logic [2:0] KEY_FIELD   = 3'd1;
    localparam logic [2:0] KEY_INC     = 3'd2;
    localparam logic [2:0] KEY_SILENCE = 3'd3;
    localparam logic [2:0] KEY_REPORT  = 3'd4;

    // Modes
    localparam logic [1:0] MODE_RUN       = 2'd0;
    localparam logic [1:0] MODE_SET_CLOCK = 2'd1;
    localparam logic [1:0] MODE_SET_ALARM = 2'd2;

    // Field selectors
    localparam logic [1:0] FIELD_HOUR   = 2'd0;
    localparam logic [1:0] FIELD_MINUTE = 2'd1;
    localparam logic [1:0] FIELD_SECOND = 2'd2;

    // Wrap points
    localparam logic [5:0] HOURS_PER_DAY = 6'd24;
    localparam logic [5:0] MINS_PER_HOUR = 6'd60;
    localparam logic [5:0] SECS_PER_MIN  = 6'd60;
    localparam logic [5:0] TONE_STEPS    = 6'd20;
    localparam logic [5:0] MODE_COUNT    = 6'd3;
    localparam logic [5:0] FIELD_COUNT   = 6'd3;

    // Power-up alarm time
    localparam logic [4:0] ALARM_HOUR_INIT   = 5'd11;
    localparam logic [5:0] ALARM_MINUTE_INIT = 6'd45;
    localparam logic [5:0] ALARM_SECOND_INIT = 6'd14;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] alarm_hour;
        logic [5:0] alarm_minute;
        logic [5:0] alarm_second;
        logic [1:0] mode;
        logic [1:0] clock_field;
        logic [1:0] alarm_field;
        logic       ringing;
        logic [4:0] tone_step;
        logic       report_enable;
    } acc_state_t;

    localparam acc_state_t STATE_INIT = '{
        hour:          5'd0,
        minute:        6'd0,
        second:        6'd0,
        alarm_hour:    ALARM_HOUR_INIT,
        alarm_minute:  ALARM_MINUTE_INIT,
        alarm_second:  ALARM_SECOND_INIT,
        mode:          MODE_RUN,
        clock_field:   FIELD_HOUR,
        alarm_field:   FIELD_HOUR,
        ringing:       1'b0,
        tone_step:     5'd0,
        report_enable: 1'b0
    };

    // Advance a counter, wrap to zero at or above the modulus
    function automatic logic [5:0] wrap_inc(input logic [5:0] v, input logic [5:0] modulus);
        logic [6:0] sum;
        sum = {1'b0, v} + 7'd1;
        return (sum >= {1'b0, modulus}) ? 6'd0 : sum[5:0];
    endfunction

endpackage

`default_nettype wire

// File: design/acc_if.sv
// Handshake channels of the alarm clock controller: event input and state output.
`default_nettype none

interface acc_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [2:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface acc_stat_if import acc_pkg::*;;
    logic       valid;
    logic       ready;
    acc_state_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/acc_step.sv
// Next-state logic for one event of the alarm clock controller.
`default_nettype none

module acc_step import acc_pkg::*;
(
    input  acc_state_t state,
    input  logic [1:0] op,
    input  logic [2:0] key,
    output acc_state_t state_next
);

    acc_state_t s;
    logic [5:0] sec_inc;
    logic [5:0] min_inc;

    always_comb
    begin
        s = state;

        // Alarm compare happens on the stored time before the action
        if (s.hour == s.alarm_hour && s.minute == s.alarm_minute
            && s.second == s.alarm_second)
        begin
            s.ringing   = 1'b1;
            s.tone_step = 5'd0;
        end

        sec_inc = wrap_inc(s.second, SECS_PER_MIN);
        min_inc = wrap_inc(s.minute, MINS_PER_HOUR);

        priority if (op == OP_SECOND)
        begin
            s.second = sec_inc;
            if (sec_inc == 6'd0)
            begin
                s.minute = min_inc;
                if (min_inc == 6'd0)
                begin
                    s.hour = 5'(wrap_inc({1'b0, s.hour}, HOURS_PER_DAY));
                end
            end
        end
        else if (op == OP_RING)
        begin
            if (s.ringing)
            begin
                s.tone_step = 5'(wrap_inc({1'b0, s.tone_step}, TONE_STEPS));
            end
        end
        else if (op == OP_KEY)
        begin
            unique case (key)
                KEY_MODE:
                begin
                    s.mode        = 2'(wrap_inc({4'd0, s.mode}, MODE_COUNT));
                    s.clock_field = FIELD_HOUR;
                    s.alarm_field = FIELD_HOUR;
                end
                KEY_FIELD:
                begin
                    if (s.mode == MODE_SET_CLOCK)
                    begin
                        s.clock_field = 2'(wrap_inc({4'd0, s.clock_field}, FIELD_COUNT));
                    end
                    else if (s.mode == MODE_SET_ALARM)
                    begin
                        s.alarm_field = 2'(wrap_inc({4'd0, s.alarm_field}, FIELD_COUNT));
                    end
                end
                KEY_INC:
                begin
                    if (s.mode == MODE_SET_CLOCK)
                    begin
                        if (s.clock_field == FIELD_HOUR)
                        begin
                            s.hour = 5'(wrap_inc({1'b0, s.hour}, HOURS_PER_DAY));
                        end
                        else if (s.clock_field == FIELD_MINUTE)
                        begin
                            s.minute = min_inc;
                        end
                        else if (s.clock_field == FIELD_SECOND)
                        begin
                            s.second = 6'd0;
                        end
                    end
                    else if (s.mode == MODE_SET_ALARM)
                    begin
                        if (s.alarm_field == FIELD_HOUR)
                        begin
                            s.alarm_hour =
                                5'(wrap_inc({1'b0, s.alarm_hour}, HOURS_PER_DAY));
                        end
                        else if (s.alarm_field == FIELD_MINUTE)
                        begin
                            s.alarm_minute = wrap_inc(s.alarm_minute, MINS_PER_HOUR);
                        end
                        else if (s.alarm_field == FIELD_SECOND)
                        begin
                            s.alarm_second = wrap_inc(s.alarm_second, SECS_PER_MIN);
                        end
                    end
                end
                KEY_SILENCE:
                begin
                    s.ringing = 1'b0;
                end
                KEY_REPORT:
                begin
                    s.report_enable = ~s.report_enable;
                end
                default:
                begin
                    // unused key codes: no action
                end
            endcase
        end
        else
        begin
            // unused op code: compare only
        end

        state_next = s;
    end

endmodule

`default_nettype wire

// File: design/alarm_clock_controller.sv
// Top level of the alarm clock controller: event register, state and result register.
//
// Usage:
//   evt    - input channel, one beat per event: op (second tick, ring tick,
//            key press) and key (mode, field select, increment, silence,
//            report toggle; looked at only for key presses).
//   status - output channel, one beat per event carrying the full clock
//            state after that event's action (time, alarm time, mode,
//            field selectors, ringing, tone step, report enable).
//   Path:    an accepted event is held in the event register; its result is then
//            loaded into the result register and offered on status.
//   Throughput: one event per cycle while status does not hold off the result
//            register; state registers update from the event register on each advance.
//   Reset: rst_n low clears both pipeline stages, sets the time to 00:00:00,
//            the alarm to 11:45:14, run mode, no ringing, report disabled.
//   Stall: while status is held off, the result register keeps its beat; the
//            event register fills and then evt.ready drops. No beat is lost.
`default_nettype none

module alarm_clock_controller import acc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    acc_evt_if.sink          evt,
    acc_stat_if.source       status
);

    // Event register stage
    logic       ev_valid_reg;
    logic [1:0] ev_op_reg;
    logic [2:0] ev_key_reg;

    // Architectural state and result register
    acc_state_t state_reg;
    acc_state_t state_next;
    logic       out_valid_reg;
    acc_state_t out_data_reg;

    logic advance;

    // Move the event into the result stage when the result register is free or drains
    assign advance   = ev_valid_reg && (!out_valid_reg || status.ready);
    assign evt.ready = !ev_valid_reg || advance;

    acc_step u_step (
        .state      (state_reg),
        .op         (ev_op_reg),
        .key        (ev_key_reg),
        .state_next (state_next)
    );

    // Capture incoming events; hold them while the result side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            ev_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            ev_op_reg  <= evt.op;
            ev_key_reg <= evt.key;
        end
    end

    // Commit the event's action to the state exactly once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_INIT;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: drop the beat once taken, load the new snapshot on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= state_next;
        end
    end

    assign status.valid = out_valid_reg;
    assign status.data  = out_data_reg;

endmodule

`default_nettype wire
